FILE: sv/xgft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xgft_pkg;

  // Frame geometry
  localparam int FrameBits  = 20;
  localparam int FrameWords = 2 * FrameBits + 1;
  localparam int PosW       = $clog2(FrameWords);

  // Field widths
  localparam int CtrlW     = 3;
  localparam int PointW    = 16;
  localparam int HalfW     = 16;
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 16;

  // Register reset values
  localparam logic [CtrlW-1:0] CtrlReset = CtrlW'(1);
  localparam logic [HalfW-1:0] HalfReset = HalfW'(1);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgControlBits = 4'd0,
    CfgHalfPeriod  = 4'd1
  } cfg_reg_e;

  // Per-lane controls issued by the sequencer
  typedef struct packed {
    logic accept;  // capture a new point into the pending word
    logic load;    // move the pending word into the shift register
    logic shift;   // advance to the next bit
  } lane_ctrl_t;

  // Build one frame word: control bits, raw position, even parity
  function automatic logic [FrameBits-1:0] build_word(
    input logic [CtrlW-1:0]  ctrl,
    input logic [PointW-1:0] pos
  );
    logic [FrameBits-2:0] upper;
    upper = {ctrl, pos};
    return {upper, ^upper};
  endfunction

endpackage

`default_nettype wire

FILE: sv/xgft_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Point channel: one galvo point per word
interface xgft_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [xgft_pkg::PointW-1:0]  x_position;
  logic signed [xgft_pkg::PointW-1:0]  y_position;

  modport source (output valid, output x_position, output y_position, input ready);
  modport sink   (input valid, input x_position, input y_position, output ready);
endinterface

// Pin channel: one pin state per word
interface xgft_pin_if;
  logic valid;
  logic ready;
  logic clock_level;
  logic sync_level;
  logic x_data_level;
  logic y_data_level;
  logic last;

  modport source (output valid, output clock_level, output sync_level,
                  output x_data_level, output y_data_level, output last,
                  input ready);
  modport sink   (input valid, input clock_level, input sync_level,
                  input x_data_level, input y_data_level, input last,
                  output ready);
endinterface

// Configuration write channel
interface xgft_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [xgft_pkg::CfgIdxW-1:0]      index;
  logic [xgft_pkg::CfgDataW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/xgft_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module xgft_lane (
  input  wire logic                              clk_i,
  input  wire logic [xgft_pkg::CtrlW-1:0]        ctrl_bits_i,
  input  wire logic signed [xgft_pkg::PointW-1:0] position_i,
  input  wire xgft_pkg::lane_ctrl_t              ctrl_i,
  output logic                                   data_o
);

  logic [xgft_pkg::FrameBits-1:0] pend_q;
  logic [xgft_pkg::FrameBits-1:0] shift_q;

  // Build the word with parity as the point is taken
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      pend_q <= xgft_pkg::build_word(ctrl_bits_i, position_i);
    end
  end

  // Load a fresh frame or advance one bit, MSB first
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      shift_q <= pend_q;
    end else if (ctrl_i.shift) begin
      shift_q <= {shift_q[xgft_pkg::FrameBits-2:0], 1'b0};
    end
  end

  assign data_o = shift_q[xgft_pkg::FrameBits-1];

endmodule

`default_nettype wire

FILE: sv/xgft_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module xgft_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [xgft_pkg::HalfW-1:0]  half_period_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        x_bit_i,
  input  wire logic                        y_bit_i,
  output xgft_pkg::lane_ctrl_t             lane_ctrl_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             clock_level_o,
  output logic                             sync_level_o,
  output logic                             x_data_level_o,
  output logic                             y_data_level_o,
  output logic                             last_o
);

  localparam logic [xgft_pkg::PosW-1:0] FinalPos = xgft_pkg::PosW'(2 * xgft_pkg::FrameBits);

  logic                        pend_valid_q, pend_valid_d;
  logic                        active_q, active_d;
  logic [xgft_pkg::PosW-1:0]   pos_q, pos_d;
  logic [xgft_pkg::HalfW-1:0]  hold_q, hold_d;
  logic                        out_valid_q, out_valid_d;
  logic                        clock_q, sync_q, xd_q, yd_q, last_q;

  logic in_acc, out_free, emit, final_word, load_frame, shift_bit;

  // Handshake and emit decisions
  assign in_ready_o = !pend_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = active_q && (hold_q == '0) && out_free;
  assign final_word = (pos_q == FinalPos);
  assign shift_bit  = emit && !final_word && pos_q[0];
  assign load_frame = pend_valid_q && (!active_q || (emit && final_word));

  assign lane_ctrl_o = '{accept: in_acc, load: load_frame, shift: shift_bit};

  // Advance frame position, pending slot and hold timer
  always_comb begin
    pend_valid_d = pend_valid_q;
    active_d     = active_q;
    pos_d        = pos_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q;

    if (in_acc) begin
      pend_valid_d = 1'b1;
    end else if (load_frame) begin
      pend_valid_d = 1'b0;
    end

    if (hold_q != '0) begin
      hold_d = hold_q - xgft_pkg::HalfW'(1);
    end

    if (emit) begin
      out_valid_d = 1'b1;
      hold_d      = (half_period_i == '0) ? '0 : half_period_i - xgft_pkg::HalfW'(1);
      if (final_word) begin
        active_d = 1'b0;
        pos_d    = '0;
      end else begin
        pos_d = pos_q + xgft_pkg::PosW'(1);
      end
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (load_frame) begin
      active_d = 1'b1;
      pos_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      active_q     <= 1'b0;
      pos_q        <= '0;
      hold_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      active_q     <= active_d;
      pos_q        <= pos_d;
      hold_q       <= hold_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Merge the lane bits into the output word
  always_ff @(posedge clk_i) begin
    if (emit) begin
      clock_q <= !final_word && pos_q[0];
      sync_q  <= !final_word;
      xd_q    <= !final_word && x_bit_i;
      yd_q    <= !final_word && y_bit_i;
      last_q  <= final_word;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign clock_level_o  = clock_q;
  assign sync_level_o   = sync_q;
  assign x_data_level_o = xd_q;
  assign y_data_level_o = yd_q;
  assign last_o         = last_q;

`ifndef SYNTH
  a_no_load_and_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load_frame && shift_bit)) else $error("lane load and shift together");
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= FinalPos) else $error("frame position out of range");
  a_idle_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> pos_q == '0) else $error("idle sequencer with nonzero position");
  a_emit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q) else $error("emitted word not presented");
  a_load_needs_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_frame |=> active_q) else $error("frame load did not start a frame");
`endif

endmodule

`default_nettype wire

FILE: sv/xy2_100_galvo_frame_transmitter.sv
`timescale 1ns / 1ps
`default_nettype none

// XY2-100 galvo frame transmitter.
// in_i takes one point word (signed X and Y). Each point becomes two 20-bit
// frame words (control bits, raw position, even parity) sent in parallel by
// an X lane and a Y lane, MSB first. out_o emits 41 pin-state words per
// point: clock low then clock high for each bit with sync high, then one
// all-low word with last set.
// cfg_i writes control_bits (index 0) and half_period_cycles (index 1); other
// indexes are ignored. Write only while the block is idle.
// From idle, the point is registered in the pending slot, loaded into the
// lane shift registers, and the first pin word is then registered on out_o.
// Pacing: the hold timer is reloaded from half_period_cycles with each pin
// word (a value of zero acts as one), and the next word waits for it to
// expire. One point waits in a pending slot while the previous frame is sent,
// so frames follow each other with no gap.
// A stalled receiver holds the current word; the next word is presented only
// after it is taken and its hold time has passed.
// Reset clears the pending slot and the frame sequencer and sets the
// registers to control_bits = 1, half_period_cycles = 1.

module xy2_100_galvo_frame_transmitter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  xgft_point_if.sink  in_i,
  xgft_pin_if.source  out_o,
  xgft_cfg_if.sink    cfg_i
);

  logic [xgft_pkg::CtrlW-1:0] ctrl_bits_q;
  logic [xgft_pkg::HalfW-1:0] half_period_q;
  xgft_pkg::lane_ctrl_t       lane_ctrl;
  logic                       x_bit, y_bit;

  // Take configuration writes at any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_bits_q   <= xgft_pkg::CtrlReset;
      half_period_q <= xgft_pkg::HalfReset;
    end else if (cfg_i.valid) begin
      unique case (xgft_pkg::cfg_reg_e'(cfg_i.index))
        xgft_pkg::CfgControlBits: ctrl_bits_q <= cfg_i.data[xgft_pkg::CtrlW-1:0];
        xgft_pkg::CfgHalfPeriod:  half_period_q <= cfg_i.data[xgft_pkg::HalfW-1:0];
        default: ;
      endcase
    end
  end

  // X and Y lanes
  xgft_lane u_lane_x (
    .clk_i       (clk_i),
    .ctrl_bits_i (ctrl_bits_q),
    .position_i  (in_i.x_position),
    .ctrl_i      (lane_ctrl),
    .data_o      (x_bit)
  );

  xgft_lane u_lane_y (
    .clk_i       (clk_i),
    .ctrl_bits_i (ctrl_bits_q),
    .position_i  (in_i.y_position),
    .ctrl_i      (lane_ctrl),
    .data_o      (y_bit)
  );

  // Sequencer and output merge
  xgft_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .half_period_i  (half_period_q),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .x_bit_i        (x_bit),
    .y_bit_i        (y_bit),
    .lane_ctrl_o    (lane_ctrl),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .clock_level_o  (out_o.clock_level),
    .sync_level_o   (out_o.sync_level),
    .x_data_level_o (out_o.x_data_level),
    .y_data_level_o (out_o.y_data_level),
    .last_o         (out_o.last)
  );

endmodule

`default_nettype wire
